@@ rtl/bqcm_pkg.sv @@
// Package: shared types, character codes and error codes for the masker.
`default_nettype none
package bqcm_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_MASK   = 8'd95;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_DQUOTE = 8'd34;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_COMMENT  = 3'd1;
    localparam logic [2:0] ERR_BAD_CLOSE = 3'd2;
    localparam logic [2:0] ERR_OPEN_QUOTE = 3'd3;
    localparam logic [2:0] ERR_OPEN_BRACKET = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  masked_byte;
        logic [2:0]  error_code;
        logic [31:0] error_offset;
        logic        last_result;
    } t_out_item;

    // Shift control shared by every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } t_bracket;

    // Opening brackets ( [ { < map to kinds 0..3.
    function automatic t_bracket open_kind(input logic [7:0] c);
        t_bracket r;
        r = '0;
        case (c)
            8'd40:   r = '{hit: 1'b1, kind: 2'd0};
            8'd91:   r = '{hit: 1'b1, kind: 2'd1};
            8'd123:  r = '{hit: 1'b1, kind: 2'd2};
            8'd60:   r = '{hit: 1'b1, kind: 2'd3};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Closing brackets ) ] } > map to kinds 0..3.
    function automatic t_bracket close_kind(input logic [7:0] c);
        t_bracket r;
        r = '0;
        case (c)
            8'd41:   r = '{hit: 1'b1, kind: 2'd0};
            8'd93:   r = '{hit: 1'b1, kind: 2'd1};
            8'd125:  r = '{hit: 1'b1, kind: 2'd2};
            8'd62:   r = '{hit: 1'b1, kind: 2'd3};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bqcm_stream_if.sv @@
// Interface: valid/ready stream channel with a typed payload.
`default_nettype none
interface bqcm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bqcm_cell.sv @@
// Stack cell: holds one bracket kind, shifts toward the top or the bottom.
`default_nettype none
module bqcm_cell (
    input  wire logic                 i_clk,
    input  wire bqcm_pkg::t_stack_ctl i_ctl,
    input  wire logic [1:0]           i_prev,   // neighbor nearer the top
    input  wire logic [1:0]           i_next,   // neighbor nearer the bottom
    output logic [1:0]                o_kind
);
    import bqcm_pkg::*;

    logic [1:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_kind <= i_prev;
        end else if (i_ctl.pop) begin
            r_kind <= i_next;
        end
    end

    assign o_kind = r_kind;
endmodule
`default_nettype wire

@@ rtl/bracket_quote_comment_masker.sv @@
// Top level: bracket, quote and comment masker over a byte stream.
//
//  channel   dir  payload                                        accepted when
//  i_in      in   text_byte[7:0], end_of_text                    valid & ready
//  o_out     out  masked_byte[7:0], error_code[2:0],             valid & ready
//                 error_offset[31:0], last_result
//
// One item per cycle unless the sink stalls: each accepted byte is processed
// when taken, and its result sits in the output register the next cycle.
// The bracket stack is a row of STACK_DEPTH cells with the top in cell 0;
// a push shifts every cell down one place, a pop shifts every cell up, so
// the top kind is always at a fixed place and no memory port is involved.
// Input ready is low only while a result waits and the sink is stalled.
// Reset (synchronous, active low) clears flags, level, offsets and errors;
// the same clear happens after the item that carries end_of_text.
`default_nettype none
module bracket_quote_comment_masker #(
    parameter int STACK_DEPTH = bqcm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bqcm_stream_if.sink   i_in,
    bqcm_stream_if.source o_out
);
    import bqcm_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    // control state
    logic          r_in_quote, n_in_quote;
    logic          r_after_esc, n_after_esc;
    logic          r_in_comment, n_in_comment;
    logic [LW-1:0] r_level, n_level;
    logic [31:0]   r_pos;
    logic [2:0]    r_err, n_err;
    logic [31:0]   r_err_off, n_err_off;

    // output register
    logic          r_out_valid;
    t_out_item     r_out, n_out;

    logic          accept;
    t_in_item      item;
    t_stack_ctl    stack_ctl;
    logic [1:0]    push_kind;
    logic [1:0]    cell_kind [STACK_DEPTH];
    t_bracket      op, cl;
    logic          run;
    logic          comment_live;
    logic [2:0]    step_err;
    logic [7:0]    masked;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign item       = i_in.data;
    assign op         = open_kind(item.text_byte);
    assign cl         = close_kind(item.text_byte);
    assign run        = (r_err == ERR_NONE);

    // Per-byte decision. Erroring bytes leave the state untouched.
    always_comb begin
        n_in_quote   = r_in_quote;
        n_after_esc  = r_after_esc;
        n_in_comment = r_in_comment;
        n_level      = r_level;
        push_kind    = op.kind;
        stack_ctl    = '0;
        step_err     = ERR_NONE;
        masked       = item.text_byte;
        // a newline closes the comment, then counts as an ordinary byte
        comment_live = r_in_comment && (item.text_byte != CH_NL);

        if (run) begin
            if (comment_live) begin
                masked = CH_HASH;
            end else if (r_in_quote) begin
                masked = CH_MASK;
                if (r_after_esc) begin
                    n_after_esc = 1'b0;
                end else if (item.text_byte == CH_BSLASH) begin
                    n_after_esc = 1'b1;
                end else if (item.text_byte == CH_DQUOTE) begin
                    n_in_quote = 1'b0;
                end
            end else begin
                n_in_comment = 1'b0;
                if (item.text_byte == CH_HASH) begin
                    if (r_level != '0) begin
                        step_err     = ERR_COMMENT;
                        n_in_comment = r_in_comment;
                    end else begin
                        n_in_comment = 1'b1;
                        masked       = CH_HASH;
                    end
                end else if (item.text_byte == CH_DQUOTE) begin
                    n_in_quote = 1'b1;
                    masked     = CH_MASK;
                end else if (op.hit) begin
                    if (r_level == LEVEL_FULL) begin
                        step_err     = ERR_OVERFLOW;
                        n_in_comment = r_in_comment;
                    end else begin
                        stack_ctl.push = 1'b1;
                        n_level        = r_level + 1'b1;
                        masked         = CH_MASK;
                    end
                end else if (cl.hit) begin
                    if (r_level == '0 || cell_kind[0] != cl.kind) begin
                        step_err     = ERR_BAD_CLOSE;
                        n_in_comment = r_in_comment;
                    end else begin
                        stack_ctl.pop = 1'b1;
                        n_level       = r_level - 1'b1;
                        masked        = CH_MASK;
                    end
                end else if (r_level != '0) begin
                    masked = CH_MASK;
                end
            end
        end

        // error latch, including the end-of-text checks
        n_err     = r_err;
        n_err_off = r_err_off;
        if (step_err != ERR_NONE) begin
            n_err     = step_err;
            n_err_off = r_pos;
        end else if (run && item.end_of_text) begin
            if (n_in_quote) begin
                n_err     = ERR_OPEN_QUOTE;
                n_err_off = r_pos + 32'd1;
            end else if (n_level != '0) begin
                n_err     = ERR_OPEN_BRACKET;
                n_err_off = r_pos + 32'd1;
            end
        end

        n_out.masked_byte  = masked;
        n_out.error_code   = n_err;
        n_out.error_offset = n_err_off;
        n_out.last_result  = item.end_of_text;

        if (!accept) begin
            stack_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote   <= 1'b0;
            r_after_esc  <= 1'b0;
            r_in_comment <= 1'b0;
            r_level      <= '0;
            r_pos        <= '0;
            r_err        <= ERR_NONE;
            r_err_off    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                if (item.end_of_text) begin
                    // text done: everything back to reset values
                    r_in_quote   <= 1'b0;
                    r_after_esc  <= 1'b0;
                    r_in_comment <= 1'b0;
                    r_level      <= '0;
                    r_pos        <= '0;
                    r_err        <= ERR_NONE;
                    r_err_off    <= '0;
                end else begin
                    r_in_quote   <= n_in_quote;
                    r_after_esc  <= n_after_esc;
                    r_in_comment <= n_in_comment;
                    r_level      <= n_level;
                    r_pos        <= r_pos + 32'd1;
                    r_err        <= n_err;
                    r_err_off    <= n_err_off;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Stack cells: cell 0 is the top; push feeds it the new kind.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [1:0] prev_kind;
        logic [1:0] next_kind;

        if (g == 0) begin : g_top
            assign prev_kind = push_kind;
        end else begin : g_mid
            assign prev_kind = cell_kind[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign next_kind = '0;
        end else begin : g_inner
            assign next_kind = cell_kind[g+1];
        end

        bqcm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (stack_ctl),
            .i_prev (prev_kind),
            .i_next (next_kind),
            .o_kind (cell_kind[g])
        );
    end

endmodule
`default_nettype wire
